// ===== rtl/core/sha256_stream_hasher_macros.svh =====
// Assertion macros shared by the hasher modules.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Constants, types and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos = 56;
    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [31:0] word_t;

    // Commands from the controller to the datapath.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD_W,
        CMD_ROUND_INIT,
        CMD_ROUND,
        CMD_FOLD,
        CMD_RESTART
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t    cmd;
        logic [5:0] idx;
    } dp_ctrl_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t initial_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha_stream_if.sv =====
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, digest_word, word_index, final_word, input ready);
    modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

// ===== rtl/core/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, round registers and chaining words.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_macros.svh"

module sha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::dp_ctrl_t ctrl,
    input  logic              buf_wr,
    input  logic [5:0]        buf_wr_addr,
    input  logic [7:0]        buf_wr_data,
    input  logic [5:0]        buf_rd_addr,
    input  logic [2:0]        out_sel,
    output sha_pkg::word_t    out_word
);

    logic [7:0] rd_byte;
    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t w_new, s0, s1, t1, t2, e, a, w_cur;

    sha_ram #(.Width(8), .Depth(sha_pkg::BlockBytes)) u_buf (
        .clk(clk), .wr_en(buf_wr), .wr_addr(buf_wr_addr), .wr_data(buf_wr_data),
        .rd_addr(buf_rd_addr), .rd_data(rd_byte)
    );

    // w_reg[0] is always the current round's schedule word.
    always_comb
    begin
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(ctrl.idx) + w_cur;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            sha_pkg::CMD_LOAD_W:
            begin
                // Bytes arrive in order; shift them in from the top word.
                w_reg[15] <= {w_reg[15][23:0], rd_byte};
                for (int i = 0; i < 15; i++)
                begin
                    if (ctrl.idx[1:0] == 2'd0)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                end
            end
            sha_pkg::CMD_ROUND_INIT:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            sha_pkg::CMD_ROUND:
            begin
                for (int i = 1; i < 8; i++)
                begin
                    v_reg[i] <= v_reg[i - 1];
                end
                v_reg[4] <= v_reg[3] + t1;
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= w_new;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::initial_h(3'(i));
            end
        end
        else if (ctrl.cmd == sha_pkg::CMD_FOLD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (ctrl.cmd == sha_pkg::CMD_RESTART)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::initial_h(3'(i));
            end
        end
    end

    assign out_word = h_reg[out_sel];

endmodule

// ===== rtl/core/sha_control.sv =====
// ----------------------------------------------------------------------------
// sha_control
// Sequencer: byte intake, padding, block compression and digest output.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_macros.svh"

module sha_control (
    input  logic              clk,
    input  logic              rst_n,
    sha_in_if.sink            in_ch,
    sha_out_if.source         out_ch,
    output sha_pkg::dp_ctrl_t ctrl,
    output logic              buf_wr,
    output logic [5:0]        buf_wr_addr,
    output logic [7:0]        buf_wr_data,
    output logic [5:0]        buf_rd_addr,
    output logic [2:0]        out_sel,
    input  sha_pkg::word_t    out_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] count_reg;
    logic        last_reg;
    logic        len_done_reg;
    logic [6:0]  step_reg;
    logic [5:0]  pos_reg;
    logic [2:0]  oidx_reg;
    logic        pad_blk_reg;
    logic        accept;
    logic [63:0] bits;
    logic [2:0]  len_byte;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign bits = {count_reg[60:0], 3'b000};
    assign len_byte = 3'(7 - pos_reg[2:0]);

    always_comb
    begin
        buf_wr = 1'b0;
        buf_wr_addr = pos_reg;
        buf_wr_data = 8'h00;
        if (state_reg == S_IDLE && accept && in_ch.byte_present)
        begin
            buf_wr = 1'b1;
            buf_wr_addr = count_reg[5:0];
            buf_wr_data = in_ch.data_byte;
        end
        else if (state_reg == S_PAD)
        begin
            buf_wr = 1'b1;
            if (!pad_blk_reg)
            begin
                buf_wr_data = sha_pkg::PadByte;
            end
            else if (len_done_reg && pos_reg >= 6'(sha_pkg::LenPos))
            begin
                buf_wr_data = bits[8 * len_byte +: 8];
            end
        end
    end

    assign buf_rd_addr = step_reg[5:0];
    assign out_sel = oidx_reg;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.digest_word = out_word;
    assign out_ch.word_index = oidx_reg;
    assign out_ch.final_word = (oidx_reg == 3'd7);

    always_comb
    begin
        ctrl.idx = (state_reg == S_LOAD) ? 6'(step_reg - 7'd1) : step_reg[5:0];
        case (state_reg)
            S_LOAD: ctrl.cmd = (step_reg == 7'd0) ? sha_pkg::CMD_NONE : sha_pkg::CMD_LOAD_W;
            S_ROUND: ctrl.cmd = sha_pkg::CMD_ROUND;
            S_FOLD: ctrl.cmd = sha_pkg::CMD_FOLD;
            default: ctrl.cmd = sha_pkg::CMD_NONE;
        endcase
        if (state_reg == S_LOAD && step_reg == 7'd64)
        begin
            ctrl.cmd = sha_pkg::CMD_LOAD_W;
        end
        if (state_reg == S_OUT && out_ch.ready && oidx_reg == 3'd7)
        begin
            ctrl.cmd = sha_pkg::CMD_RESTART;
        end
        if (state_reg == S_ROUND && step_reg == 7'd0)
        begin
            ctrl.cmd = sha_pkg::CMD_ROUND_INIT;
        end
    end

    // Round phase: step 0 copies the chain into the working set, then 64 rounds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            last_reg <= 1'b0;
            len_done_reg <= 1'b0;
            step_reg <= '0;
            pos_reg <= '0;
            oidx_reg <= '0;
            pad_blk_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= in_ch.end_of_message;
                        step_reg <= '0;
                        if (in_ch.byte_present)
                        begin
                            count_reg <= count_reg + 64'd1;
                            pos_reg <= 6'(count_reg[5:0] + 6'd1);
                            if (count_reg[5:0] == 6'd63)
                            begin
                                state_reg <= S_LOAD;
                            end
                            else if (in_ch.end_of_message)
                            begin
                                state_reg <= S_PAD;
                                pad_blk_reg <= 1'b0;
                            end
                        end
                        else if (in_ch.end_of_message)
                        begin
                            pos_reg <= count_reg[5:0];
                            state_reg <= S_PAD;
                            pad_blk_reg <= 1'b0;
                        end
                    end
                end
                S_PAD:
                begin
                    // Marker byte first, then zeros, then length if it fits.
                    pad_blk_reg <= 1'b1;
                    pos_reg <= pos_reg + 6'd1;
                    if (!pad_blk_reg && pos_reg >= 6'(sha_pkg::LenPos))
                    begin
                        len_done_reg <= 1'b0;
                    end
                    else if (!pad_blk_reg)
                    begin
                        len_done_reg <= 1'b1;
                    end
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= S_LOAD;
                        step_reg <= '0;
                    end
                end
                S_LOAD:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd64)
                    begin
                        state_reg <= S_ROUND;
                        step_reg <= '0;
                    end
                end
                S_ROUND:
                begin
                    if (step_reg == 7'd0)
                    begin
                        step_reg <= 7'd64;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                        if (step_reg == 7'd127)
                        begin
                            state_reg <= S_FOLD;
                        end
                    end
                end
                S_FOLD:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (!pad_blk_reg)
                    begin
                        state_reg <= S_PAD;
                        pos_reg <= count_reg[5:0];
                    end
                    else if (!len_done_reg)
                    begin
                        state_reg <= S_PAD;
                        len_done_reg <= 1'b1;
                        pos_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        oidx_reg <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            state_reg <= S_IDLE;
                            count_reg <= '0;
                            len_done_reg <= 1'b0;
                            pad_blk_reg <= 1'b0;
                            last_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SHA_ASSERT_IMP(a_out_only_in_out, clk, rst_n, out_ch.valid, !in_ch.ready)
    `SHA_ASSERT_NEXT(a_final_returns_idle, clk, rst_n,
        out_ch.valid && out_ch.ready && out_ch.final_word, in_ch.ready && count_reg == 64'd0)
    `SHA_ASSERT_NEXT(a_full_block_loads, clk, rst_n,
        accept && in_ch.byte_present && count_reg[5:0] == 6'd63, state_reg == S_LOAD)

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 digest of a byte stream, at most one byte per input beat.
// ----------------------------------------------------------------------------
// The beat that completes a 64-byte block starts a compression: the schedule
// is loaded through the one-byte read port of the block RAM, the chain is
// copied, 64 rounds run on the single round unit, and the result is folded
// in. The last beat pads one byte per cycle from the fill position to the
// end of the block, and a fresh block too when the length does not fit;
// it compresses once or twice, then offers the eight digest words h0..h7,
// one per beat. Input is not taken during that work.
module sha256_stream_hasher (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    sha_pkg::dp_ctrl_t ctrl;
    logic              buf_wr;
    logic [5:0]        buf_wr_addr;
    logic [7:0]        buf_wr_data;
    logic [5:0]        buf_rd_addr;
    logic [2:0]        out_sel;
    sha_pkg::word_t    out_word;

    sha_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .ctrl(ctrl),
        .buf_wr(buf_wr), .buf_wr_addr(buf_wr_addr), .buf_wr_data(buf_wr_data),
        .buf_rd_addr(buf_rd_addr), .out_sel(out_sel), .out_word(out_word)
    );

    sha_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .buf_wr(buf_wr),
        .buf_wr_addr(buf_wr_addr), .buf_wr_data(buf_wr_data),
        .buf_rd_addr(buf_rd_addr), .out_sel(out_sel), .out_word(out_word)
    );

endmodule

// ===== sim/sha256_digest_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the byte and digest channels of the hasher, computes the SHA-256
// digest of every message it sees accepted, and compares each digest beat
// with the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_data_byte,
    input  logic        in_byte_present,
    input  logic        in_end_of_message,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_digest_word,
    input  logic [2:0]  out_word_index,
    input  logic        out_final_word,
    output int          error_count,
    output int          pending_words,
    output int          digests_seen
);

    typedef struct packed {
        sha_pkg::word_t digest_word;
        logic [2:0]     word_index;
        logic           final_word;
    } digest_beat_t;

    localparam sha_pkg::word_t RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam sha_pkg::word_t StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha_pkg::word_t hash_state [8];
    logic [7:0]     msg_block [64];
    logic [63:0]    msg_bytes;
    digest_beat_t   digest_queue [$];

    function automatic sha_pkg::word_t ror32(sha_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        sha_pkg::word_t w [64];
        sha_pkg::word_t v [8];
        sha_pkg::word_t t1;
        sha_pkg::word_t t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--)
                v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic absorb_beat(logic [7:0] b, logic present, logic last);
        int          pos;
        logic [63:0] bit_len;
        digest_beat_t beat;
        if (present)
        begin
            pos = int'(msg_bytes[5:0]);
            msg_block[pos] = b;
            msg_bytes = msg_bytes + 64'd1;
            if (pos == 63)
                compress_block();
        end
        if (last)
        begin
            pos = int'(msg_bytes[5:0]);
            bit_len = msg_bytes << 3;
            msg_block[pos] = sha_pkg::PadByte;
            pos++;
            // The length no longer fits: close this block and pad a fresh one.
            if (pos > sha_pkg::LenPos)
            begin
                while (pos < sha_pkg::BlockBytes)
                begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < sha_pkg::LenPos)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                msg_block[63-i] = bit_len[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                beat.digest_word = hash_state[i];
                beat.word_index = 3'(i);
                beat.final_word = (i == 7);
                digest_queue.push_back(beat);
            end
            hash_state = StartHash;
            msg_bytes = '0;
        end
    endtask

    initial
    begin
        hash_state = StartHash;
        msg_bytes = '0;
        error_count = 0;
        digests_seen = 0;
        pending_words = 0;
    end

    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_beat(in_data_byte, in_byte_present, in_end_of_message);
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected digest beat %h idx %0d", $time,
                             out_digest_word, out_word_index);
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (out_digest_word !== want.digest_word)
                    begin
                        error_count++;
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 want.digest_word, out_digest_word);
                    end
                    if (out_word_index !== want.word_index)
                    begin
                        error_count++;
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 want.word_index, out_word_index);
                    end
                    if (out_final_word !== want.final_word)
                    begin
                        error_count++;
                        $display("%0t: final_word expected %b actual %b", $time,
                                 want.final_word, out_final_word);
                    end
                    if (want.final_word)
                        digests_seen++;
                end
            end
            pending_words = digest_queue.size();
        end
    end
endmodule

// ===== sim/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Drives messages of assorted lengths through the hasher, around every
// padding boundary, with bursty input and a stalling receiver; a checker
// beside the block predicts and compares every digest beat.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

    localparam int CycleLimit = 400000;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    int   pending_words;
    int   digests_seen;
    int   bytes_sent;
    int   burst_left;
    int   stall_phase;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sha256_digest_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_ch.valid),
        .in_ready          (in_ch.ready),
        .in_data_byte      (in_ch.data_byte),
        .in_byte_present   (in_ch.byte_present),
        .in_end_of_message (in_ch.end_of_message),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_digest_word   (out_ch.digest_word),
        .out_word_index    (out_ch.word_index),
        .out_final_word    (out_ch.final_word),
        .error_count       (error_count),
        .pending_words     (pending_words),
        .digests_seen      (digests_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver stalls are random, with stall-free stretches between.
    initial
    begin
        out_ch.ready = 1'b0;
        stall_phase = 0;
        forever
        begin
            @(posedge clk);
            stall_phase++;
            if ((stall_phase / 200) % 3 == 0)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 9) > 3);
        end
    end

    // Sends one beat and holds it until the block takes it. Gaps come between
    // bursts only, so valid is never dropped and raised in the same step.
    task automatic send_beat(logic [7:0] b, logic present, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.byte_present <= present;
        in_ch.end_of_message <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // A message of len bytes, random or all ones, with empty items sprinkled in;
    // the last byte may ride on the closing item or be followed by an empty one.
    task automatic send_message(int len, logic all_ones);
        logic [7:0] b;
        logic       tail_on_last;
        tail_on_last = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            b = all_ones ? 8'hff : 8'($urandom);
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(b, 1'b1, (i == len - 1) && tail_on_last);
        end
        if (!tail_on_last)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        int pick;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        bytes_sent = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, empty items alone, extreme byte values,
        // and lengths at the padding and block boundaries.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_message(3, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        send_message(65, 1'b0);

        // Random: mostly short messages, a few crossing block boundaries.
        while (bytes_sent < 380)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(100, 140);
            if (len > 380 - bytes_sent)
                len = 380 - bytes_sent;
            send_message(len, 1'b0);
        end
        in_ch.valid <= 1'b0;

        while (pending_words != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d beats; %0d digests compared, lengths 0 to 140 bytes.",
                 bytes_sent, digests_seen);
        $display("Both padding cases, empty items and stalls on both sides were exercised.");
        if (error_count == 0 && pending_words == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
